/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Short forms for the concurrent assertions used by the checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked only while reset is released.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked only while reset is released.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that is also checked around reset.
`define ASSERT_NXT_ALWAYS(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/tds_pkg.sv */
// ----------------------------------------------------------------------------
// tds_pkg
// Shared types and character constants of the definition name scanner.
// ----------------------------------------------------------------------------
package tds_pkg;

    localparam int unsigned BYTE_W = 8;

    // Output queue depth; one step can push two words.
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam logic [BYTE_W-1:0] CH_SLASH = 8'h2F;
    localparam logic [BYTE_W-1:0] CH_STAR  = 8'h2A;
    localparam logic [BYTE_W-1:0] CH_SQ    = 8'h27;
    localparam logic [BYTE_W-1:0] CH_DQ    = 8'h22;
    localparam logic [BYTE_W-1:0] CH_BSL   = 8'h5C;
    localparam logic [BYTE_W-1:0] CH_NL    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
    localparam logic [BYTE_W-1:0] CH_USCORE = 8'h5F;
    localparam logic [BYTE_W-1:0] CH_LO_F  = 8'h66;
    localparam logic [BYTE_W-1:0] CH_LO_U  = 8'h75;
    localparam logic [BYTE_W-1:0] CH_LO_N  = 8'h6E;
    localparam logic [BYTE_W-1:0] CH_LO_C  = 8'h63;
    localparam logic [BYTE_W-1:0] CH_LO_L  = 8'h6C;
    localparam logic [BYTE_W-1:0] CH_LO_A  = 8'h61;
    localparam logic [BYTE_W-1:0] CH_LO_S  = 8'h73;

    // One output word: a name byte and its end-of-name flag.
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } t_entry;

    // Words produced by one scanner step, first word in w0.
    typedef struct packed {
        logic [1:0] count;
        t_entry     w0;
        t_entry     w1;
    } t_result;

endpackage

/* rtl/core/tds_scan.sv */
// ----------------------------------------------------------------------------
// tds_scan
// Lexical state and keyword matcher; one text byte per step.
// ----------------------------------------------------------------------------
module tds_scan
    import tds_pkg::*;
#(
    parameter int unsigned MAX_NAME = 255
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [BYTE_W-1:0] i_byte,
    input  logic              i_last,
    output t_result           o_result
);

    localparam int unsigned CNT_W = $clog2(MAX_NAME + 1);

    typedef enum logic [2:0] {
        M_NORMAL = 3'd0,
        M_LINE   = 3'd1,
        M_BLOCK  = 3'd2,
        M_SQ     = 3'd3,
        M_DQ     = 3'd4
    } t_mode;

    typedef enum logic [3:0] {
        P_IDLE  = 4'd0,
        P_F     = 4'd1,
        P_FU    = 4'd2,
        P_FUN   = 4'd3,
        P_C     = 4'd4,
        P_CL    = 4'd5,
        P_CLA   = 4'd6,
        P_CLAS  = 4'd7,
        P_CLASS = 4'd8,
        P_BLANK = 4'd9,
        P_IDENT = 4'd10
    } t_phase;

    t_mode             r_mode,  n_mode;
    t_phase            r_phase, n_phase;
    logic              r_esc,   n_esc;
    logic              r_ls,    n_ls;
    logic              r_sp,    n_sp;
    logic              r_st,    n_st;
    logic [BYTE_W-1:0] r_held,  n_held;
    logic [CNT_W-1:0]  r_count, n_count;

    function automatic logic f_id_start(input logic [BYTE_W-1:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == CH_USCORE;
    endfunction

    function automatic logic f_id_char(input logic [BYTE_W-1:0] c);
        return f_id_start(c) || (c >= 8'h30 && c <= 8'h39);
    endfunction

    function automatic logic f_blank(input logic [BYTE_W-1:0] c);
        return c == CH_SPACE || c == CH_TAB;
    endfunction

    always_comb begin
        logic at_start;
        logic [BYTE_W-1:0] quote;
        at_start = r_ls && r_mode == M_NORMAL && !r_sp;
        quote    = (r_mode == M_SQ) ? CH_SQ : CH_DQ;
        n_mode   = r_mode;
        n_phase  = r_phase;
        n_esc    = r_esc;
        n_ls     = r_ls;
        n_sp     = r_sp;
        n_st     = r_st;
        n_held   = r_held;
        n_count  = r_count;
        o_result = '0;

        // Keyword and name matcher.
        case (r_phase)
            P_IDLE: begin
                if (at_start && i_byte == CH_LO_F) begin
                    n_phase = P_F;
                end else if (at_start && i_byte == CH_LO_C) begin
                    n_phase = P_C;
                end
            end
            P_F:    n_phase = (i_byte == CH_LO_U) ? P_FU : P_IDLE;
            P_FU:   n_phase = (i_byte == CH_LO_N) ? P_FUN : P_IDLE;
            P_C:    n_phase = (i_byte == CH_LO_L) ? P_CL : P_IDLE;
            P_CL:   n_phase = (i_byte == CH_LO_A) ? P_CLA : P_IDLE;
            P_CLA:  n_phase = (i_byte == CH_LO_S) ? P_CLAS : P_IDLE;
            P_CLAS: n_phase = (i_byte == CH_LO_S) ? P_CLASS : P_IDLE;
            P_FUN, P_CLASS: begin
                n_phase = f_blank(i_byte) ? P_BLANK : P_IDLE;
            end
            P_BLANK: begin
                if (!f_blank(i_byte)) begin
                    if (f_id_start(i_byte)) begin
                        n_held  = i_byte;
                        n_count = CNT_W'(1);
                        n_phase = P_IDENT;
                    end else begin
                        n_phase = P_IDLE;
                    end
                end
            end
            P_IDENT: begin
                if (f_id_char(i_byte)) begin
                    // Bytes beyond the length limit are dropped.
                    if (r_count < CNT_W'(MAX_NAME)) begin
                        o_result.count = 2'd1;
                        o_result.w0    = '{data: r_held, last: 1'b0};
                        n_held         = i_byte;
                        n_count        = r_count + CNT_W'(1);
                    end
                end else begin
                    o_result.count = 2'd1;
                    o_result.w0    = '{data: r_held, last: 1'b1};
                    n_held         = '0;
                    n_count        = '0;
                    n_phase        = P_IDLE;
                end
            end
            default: n_phase = P_IDLE;
        endcase

        // Comment and string tracking.
        case (r_mode)
            M_LINE: begin
                if (i_byte == CH_NL) begin
                    n_mode = M_NORMAL;
                    n_ls   = 1'b1;
                end else begin
                    n_ls = 1'b0;
                end
            end
            M_BLOCK: begin
                if (r_st && i_byte == CH_SLASH) begin
                    n_mode = M_NORMAL;
                    n_st   = 1'b0;
                    n_ls   = 1'b0;
                end else begin
                    n_st = (i_byte == CH_STAR);
                    n_ls = (i_byte == CH_NL);
                end
            end
            M_SQ, M_DQ: begin
                if (!r_esc && i_byte == CH_BSL) begin
                    n_esc = 1'b1;
                    n_ls  = 1'b0;
                end else begin
                    if (!r_esc && i_byte == quote) begin
                        n_mode = M_NORMAL;
                    end
                    n_esc = 1'b0;
                    n_ls  = (i_byte == CH_NL);
                end
            end
            default: begin
                n_mode = M_NORMAL;
                if (r_sp && i_byte == CH_SLASH) begin
                    n_sp   = 1'b0;
                    n_mode = M_LINE;
                    n_ls   = 1'b0;
                end else if (r_sp && i_byte == CH_STAR) begin
                    n_sp   = 1'b0;
                    n_mode = M_BLOCK;
                    n_st   = 1'b0;
                    n_ls   = 1'b0;
                end else begin
                    n_sp = 1'b0;
                    if (i_byte == CH_SLASH) begin
                        n_sp = 1'b1;
                        n_ls = 1'b0;
                    end else if (i_byte == CH_SQ) begin
                        n_mode = M_SQ;
                        n_esc  = 1'b0;
                        n_ls   = 1'b0;
                    end else if (i_byte == CH_DQ) begin
                        n_mode = M_DQ;
                        n_esc  = 1'b0;
                        n_ls   = 1'b0;
                    end else begin
                        n_ls = (i_byte == CH_NL);
                    end
                end
            end
        endcase

        // End of text: close an open name and return to the reset state.
        if (i_last) begin
            if (n_phase == P_IDENT) begin
                if (o_result.count == 2'd0) begin
                    o_result.count = 2'd1;
                    o_result.w0    = '{data: n_held, last: 1'b1};
                end else begin
                    o_result.count = 2'd2;
                    o_result.w1    = '{data: n_held, last: 1'b1};
                end
            end
            n_mode  = M_NORMAL;
            n_phase = P_IDLE;
            n_esc   = 1'b0;
            n_ls    = 1'b1;
            n_sp    = 1'b0;
            n_st    = 1'b0;
            n_held  = '0;
            n_count = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= M_NORMAL;
            r_phase <= P_IDLE;
            r_esc   <= 1'b0;
            r_ls    <= 1'b1;
            r_sp    <= 1'b0;
            r_st    <= 1'b0;
            r_held  <= '0;
            r_count <= '0;
        end else if (i_step) begin
            r_mode  <= n_mode;
            r_phase <= n_phase;
            r_esc   <= n_esc;
            r_ls    <= n_ls;
            r_sp    <= n_sp;
            r_st    <= n_st;
            r_held  <= n_held;
            r_count <= n_count;
        end
    end

endmodule

/* rtl/core/tds_queue.sv */
// ----------------------------------------------------------------------------
// tds_queue
// Small output queue: takes up to two words a cycle, gives out one when ready.
// ----------------------------------------------------------------------------
module tds_queue
    import tds_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  t_result           i_result,
    output logic              o_room,
    output logic              o_valid,
    output logic [BYTE_W-1:0] o_data,
    output logic              o_last,
    input  logic              i_ready
);

    t_entry                  r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]     r_wp, n_wp;
    logic [QUEUE_AW-1:0]     r_rp, n_rp;
    logic [QUEUE_AW:0]       r_fill, n_fill;
    logic [1:0]              push_n;
    logic                    pop;

    assign push_n  = i_push ? i_result.count : 2'd0;
    assign o_valid = (r_fill != '0);
    assign pop     = o_valid && i_ready;
    assign o_data  = r_mem[r_rp].data;
    assign o_last  = r_mem[r_rp].last;
    // Room for a full step, judged on the registered fill alone.
    assign o_room  = (r_fill <= (QUEUE_AW + 1)'(QUEUE_DEPTH - 2));

    assign n_wp   = r_wp + QUEUE_AW'(push_n);
    assign n_rp   = r_rp + QUEUE_AW'(pop);
    assign n_fill = r_fill + (QUEUE_AW + 1)'(push_n) - (QUEUE_AW + 1)'(pop);

    always_ff @(posedge i_clk) begin
        if (push_n != 2'd0) begin
            r_mem[r_wp] <= i_result.w0;
        end
        if (push_n == 2'd2) begin
            r_mem[r_wp + QUEUE_AW'(1)] <= i_result.w1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_rp   <= '0;
            r_fill <= '0;
        end else begin
            r_wp   <= n_wp;
            r_rp   <= n_rp;
            r_fill <= n_fill;
        end
    end

endmodule

/* rtl/core/top_level_definition_name_scanner_core.sv */
// ----------------------------------------------------------------------------
// top_level_definition_name_scanner_core
// Streams out the names that follow unindented fun and class keywords.
// ----------------------------------------------------------------------------
// The source text enters one byte per word on the slave channel; tlast marks
// the final byte of a text, after which all scanner state returns to its
// reset value. The master channel carries one name byte per word, and tlast
// there flags the last byte of each name. Bytes inside comments and strings
// are never taken as keywords.
// An accepted byte waits in the input register, is stepped through the
// scanner when the output queue has room for a full step, and any word it
// produces goes into the queue, which offers it on the master side.
// Throughput: one text byte per cycle while the queue has room for a step.
// One byte can give two words (a name closed by the end of the text), which
// the four-word output queue absorbs; the slave side waits only while the
// queue holds more than two words.
// While the receiver stalls the queue fills, and once it cannot take a full
// step the input register holds its byte and tready falls.
// Reset (synchronous, active low) empties the input register and the queue
// and puts the scanner at the start of a line in plain text.
// ----------------------------------------------------------------------------
module top_level_definition_name_scanner_core
    import tds_pkg::*;
#(
    parameter int unsigned MAX_NAME = 255
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [BYTE_W-1:0] i_s_tdata,   // [7:0] text_byte
    input  logic              i_s_tlast,   // text_last
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [BYTE_W-1:0] o_m_tdata,   // [7:0] name_byte
    output logic              o_m_tlast    // name_end
);

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_in_last;
    logic              step;
    logic              room;
    t_result           result;

    // The step fires when the queue can take two words whatever it pops.
    assign step       = r_in_valid && room;
    assign o_s_tready = !r_in_valid || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_in_byte <= i_s_tdata;
            r_in_last <= i_s_tlast;
        end
    end

    tds_scan #(
        .MAX_NAME (MAX_NAME)
    ) u_scan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_byte   (r_in_byte),
        .i_last   (r_in_last),
        .o_result (result)
    );

    tds_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (step),
        .i_result (result),
        .o_room   (room),
        .o_valid  (o_m_tvalid),
        .o_data   (o_m_tdata),
        .o_last   (o_m_tlast),
        .i_ready  (i_m_tready)
    );

endmodule

/* rtl/core/tds_checker.sv */
// ----------------------------------------------------------------------------
// tds_checker
// Port-level assertions for the definition name scanner.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tds_checker
    import tds_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    input  logic              o_s_tready,
    input  logic [BYTE_W-1:0] i_s_tdata,   // [7:0] text_byte
    input  logic              i_s_tlast,   // text_last
    input  logic              o_m_tvalid,
    input  logic              i_m_tready,
    input  logic [BYTE_W-1:0] o_m_tdata,   // [7:0] name_byte
    input  logic              o_m_tlast    // name_end
);

    // A name byte is always an identifier character, never zero.
    `ASSERT_IMP(a_name_nonzero, i_clk, i_rst_n, o_m_tvalid, o_m_tdata != '0, "zero name byte")

    // A stalled output word stays offered and unchanged.
    `ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast), "output word changed while stalled")

    // Reset leaves the output queue empty.
    `ASSERT_NXT_ALWAYS(a_rst_empty, i_clk, !i_rst_n, !o_m_tvalid, "output valid after reset")

    // Reset leaves the input side ready for a byte.
    `ASSERT_NXT_ALWAYS(a_rst_ready, i_clk, !i_rst_n, o_s_tready, "input not ready after reset")

endmodule

bind top_level_definition_name_scanner_core tds_checker u_tds_checker (.*);

/* test/top_level_definition_name_scanner_core_tb.sv */
// ----------------------------------------------------------------------------
// top_level_definition_name_scanner_core_tb
// Self-checking bench for the definition name scanner.
// ----------------------------------------------------------------------------
// Source texts are fed in one byte per word. A directed set covers the corner
// cases, and random texts built from definitions, comments, strings and noise
// follow it. A cycle-free scanner model predicts every name word when its
// text byte is accepted. The monitor compares each output word with the
// oldest prediction, while both sides idle at random and the receiver holds
// off once for a long stretch.
// ----------------------------------------------------------------------------
module top_level_definition_name_scanner_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tds_pkg::*;

    localparam int unsigned NAME_LIMIT   = 255;
    localparam int          RANDOM_BYTES = 190;
    localparam int          DRAIN_CYCLES = 16;
    localparam int          HOLD_CYCLES  = 200;

    localparam logic [BYTE_W-1:0] CH_UP_A   = 8'h41;
    localparam logic [BYTE_W-1:0] CH_UP_Z   = 8'h5A;
    localparam logic [BYTE_W-1:0] CH_LO_Z   = 8'h7A;
    localparam logic [BYTE_W-1:0] CH_DIG_0  = 8'h30;
    localparam logic [BYTE_W-1:0] CH_DIG_9  = 8'h39;

    // Where the scanner stands in the text.
    typedef enum logic [2:0] {
        SCAN_CODE,
        SCAN_LINE_COMMENT,
        SCAN_BLOCK_COMMENT,
        SCAN_SQUOTE,
        SCAN_DQUOTE
    } t_scan_mode;

    // Progress through a keyword, the blanks after it and the name.
    typedef enum logic [3:0] {
        KW_IDLE, KW_F, KW_FU, KW_FUN, KW_C, KW_CL, KW_CLA, KW_CLAS, KW_CLASS,
        KW_BLANK, KW_NAME
    } t_kw_phase;

    // One text byte and its end-of-text flag.
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } t_text_word;

    logic              i_clk    = 1'b0;
    logic              i_rst_n  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic [BYTE_W-1:0] s_tdata  = '0;      // [7:0] text_byte
    logic              s_tlast  = 1'b0;    // text_last
    logic              m_tready = 1'b0;
    logic              o_s_tready;
    logic              o_m_tvalid;
    logic [BYTE_W-1:0] o_m_tdata;          // [7:0] name_byte
    logic              o_m_tlast;          // name_end

    t_text_word text_words[$];      // text bytes still to be offered
    t_entry     expected_names[$];  // predicted name words, oldest first
    t_entry     seen_word;
    t_text_word next_word;

    // Scanner model state.
    t_scan_mode        sc_mode;
    logic              sc_escape;
    logic              sc_line_start;
    logic              sc_slash;
    logic              sc_star;
    t_kw_phase         kw_phase;
    logic [BYTE_W-1:0] kw_held;
    logic [7:0]        kw_count;

    int  errors         = 0;
    int  accepted_words = 0;
    int  texts_done     = 0;
    int  name_words     = 0;
    int  names_done     = 0;
    int  input_blocked  = 0;
    int  gap            = 0;
    int  stall          = 0;
    logic hold_off      = 1'b0;

    top_level_definition_name_scanner_core #(
        .MAX_NAME (NAME_LIMIT)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tlast  (s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    always #2 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Scanner model
    // ------------------------------------------------------------------------
    function automatic logic is_blank(input logic [BYTE_W-1:0] c);
        return c == CH_SPACE || c == CH_TAB;
    endfunction

    function automatic logic is_id_start(input logic [BYTE_W-1:0] c);
        return (c >= CH_LO_A && c <= CH_LO_Z) || (c >= CH_UP_A && c <= CH_UP_Z)
            || c == CH_USCORE;
    endfunction

    function automatic logic is_id_char(input logic [BYTE_W-1:0] c);
        return is_id_start(c) || (c >= CH_DIG_0 && c <= CH_DIG_9);
    endfunction

    task automatic reset_scanner();
        sc_mode       = SCAN_CODE;
        sc_escape     = 1'b0;
        sc_line_start = 1'b1;
        sc_slash      = 1'b0;
        sc_star       = 1'b0;
        kw_phase      = KW_IDLE;
        kw_held       = '0;
        kw_count      = '0;
    endtask

    task automatic expect_word(input logic [BYTE_W-1:0] b, input logic fin);
        t_entry w;
        w.data = b;
        w.last = fin;
        expected_names.push_back(w);
    endtask

    // Advances the model by one text byte and queues the name words it gives.
    task automatic scan_text_byte(input logic [BYTE_W-1:0] c, input logic fin);
        logic              at_start;
        logic              opened;
        logic [BYTE_W-1:0] quote;
        at_start = sc_line_start && sc_mode == SCAN_CODE && !sc_slash;
        opened   = 1'b0;

        // Keyword matching looks at the state before this byte's mode update.
        case (kw_phase)
            KW_IDLE: begin
                if (at_start && c == CH_LO_F) kw_phase = KW_F;
                else if (at_start && c == CH_LO_C) kw_phase = KW_C;
            end
            KW_F:    kw_phase = (c == CH_LO_U) ? KW_FU : KW_IDLE;
            KW_FU:   kw_phase = (c == CH_LO_N) ? KW_FUN : KW_IDLE;
            KW_C:    kw_phase = (c == CH_LO_L) ? KW_CL : KW_IDLE;
            KW_CL:   kw_phase = (c == CH_LO_A) ? KW_CLA : KW_IDLE;
            KW_CLA:  kw_phase = (c == CH_LO_S) ? KW_CLAS : KW_IDLE;
            KW_CLAS: kw_phase = (c == CH_LO_S) ? KW_CLASS : KW_IDLE;
            KW_FUN, KW_CLASS: kw_phase = is_blank(c) ? KW_BLANK : KW_IDLE;
            KW_BLANK: begin
                if (!is_blank(c)) begin
                    if (is_id_start(c)) begin
                        kw_held  = c;
                        kw_count = 8'd1;
                        kw_phase = KW_NAME;
                    end else begin
                        kw_phase = KW_IDLE;
                    end
                end
            end
            KW_NAME: begin
                if (is_id_char(c)) begin
                    // Bytes past the name limit are dropped.
                    if (kw_count < NAME_LIMIT) begin
                        expect_word(kw_held, 1'b0);
                        kw_held  = c;
                        kw_count = kw_count + 8'd1;
                    end
                end else begin
                    expect_word(kw_held, 1'b1);
                    kw_held  = '0;
                    kw_count = '0;
                    kw_phase = KW_IDLE;
                end
            end
            default: kw_phase = KW_IDLE;
        endcase

        case (sc_mode)
            SCAN_LINE_COMMENT: begin
                if (c == CH_NL) begin
                    sc_mode       = SCAN_CODE;
                    sc_line_start = 1'b1;
                end else begin
                    sc_line_start = 1'b0;
                end
            end
            SCAN_BLOCK_COMMENT: begin
                if (sc_star && c == CH_SLASH) begin
                    sc_mode       = SCAN_CODE;
                    sc_star       = 1'b0;
                    sc_line_start = 1'b0;
                end else begin
                    sc_star       = (c == CH_STAR);
                    sc_line_start = (c == CH_NL);
                end
            end
            SCAN_SQUOTE, SCAN_DQUOTE: begin
                if (!sc_escape && c == CH_BSL) begin
                    sc_escape     = 1'b1;
                    sc_line_start = 1'b0;
                end else begin
                    quote = (sc_mode == SCAN_SQUOTE) ? CH_SQ : CH_DQ;
                    if (!sc_escape && c == quote) sc_mode = SCAN_CODE;
                    sc_escape     = 1'b0;
                    sc_line_start = (c == CH_NL);
                end
            end
            default: begin
                sc_mode = SCAN_CODE;
                // A pending slash either opens a comment or falls back to text.
                if (sc_slash) begin
                    sc_slash = 1'b0;
                    if (c == CH_SLASH) begin
                        sc_mode       = SCAN_LINE_COMMENT;
                        sc_line_start = 1'b0;
                        opened        = 1'b1;
                    end else if (c == CH_STAR) begin
                        sc_mode       = SCAN_BLOCK_COMMENT;
                        sc_star       = 1'b0;
                        sc_line_start = 1'b0;
                        opened        = 1'b1;
                    end
                end
                if (!opened) begin
                    if (c == CH_SLASH) begin
                        sc_slash      = 1'b1;
                        sc_line_start = 1'b0;
                    end else if (c == CH_SQ || c == CH_DQ) begin
                        sc_mode       = (c == CH_SQ) ? SCAN_SQUOTE : SCAN_DQUOTE;
                        sc_escape     = 1'b0;
                        sc_line_start = 1'b0;
                    end else begin
                        sc_line_start = (c == CH_NL);
                    end
                end
            end
        endcase

        // The end of a text closes an open name and starts afresh.
        if (fin) begin
            if (kw_phase == KW_NAME) expect_word(kw_held, 1'b1);
            reset_scanner();
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus building
    // ------------------------------------------------------------------------
    task automatic add_byte(input logic [BYTE_W-1:0] b, input logic fin);
        t_text_word w;
        w.data = b;
        w.last = fin;
        text_words.push_back(w);
    endtask

    // Marks the latest byte as the end of its text.
    task automatic finish_text();
        if (text_words.size() > 0) text_words[text_words.size() - 1].last = 1'b1;
    endtask

    task automatic add_text(input string s, input logic fin);
        for (int i = 0; i < s.len(); i++) add_byte(s[i], 1'b0);
        if (fin) finish_text();
    endtask

    function automatic logic [BYTE_W-1:0] id_char(input logic first);
        int r;
        r = $urandom_range(0, first ? 52 : 62);
        if (r < 26) return CH_LO_A + 8'(r);
        if (r < 52) return CH_UP_A + 8'(r - 26);
        if (r == 52) return CH_USCORE;
        return CH_DIG_0 + 8'(r - 53);
    endfunction

    task automatic add_name(input int len);
        for (int i = 0; i < len; i++) add_byte(id_char(i == 0), 1'b0);
    endtask

    task automatic add_noise(input int len);
        repeat (len) add_byte(8'($urandom_range(1, 255)), 1'b0);
    endtask

    // One random piece of source text: most often a definition, mostly with a
    // random name, else a comment, string, noise, a newline or the text's end.
    task automatic add_fragment();
        int                pick;
        int                n;
        logic [BYTE_W-1:0] q;
        pick = $urandom_range(0, 99);
        if (pick < 38) begin
            if ($urandom_range(0, 3) != 0) add_byte(CH_NL, 1'b0);
            if ($urandom_range(0, 9) == 0) add_byte(CH_SPACE, 1'b0);
            if ($urandom_range(0, 1)) add_text("fun", 1'b0);
            else add_text("class", 1'b0);
            n = $urandom_range(0, 9);
            if (n == 0) begin
                // Keyword run into another identifier byte.
                add_byte(id_char(1'b0), 1'b0);
            end else begin
                repeat ($urandom_range(1, 3))
                    add_byte($urandom_range(0, 1) ? CH_SPACE : CH_TAB, 1'b0);
                if (n > 1) add_name((n == 9) ? $urandom_range(9, 24) : $urandom_range(1, 8));
            end
            case ($urandom_range(0, 4))
                0:       finish_text();
                1:       add_text("(x)\n", 1'b0);
                2:       add_text(" {\n", 1'b0);
                default: add_byte(CH_NL, 1'b0);
            endcase
        end else if (pick < 48) begin
            add_text("//", 1'b0);
            if ($urandom_range(0, 1)) add_text("fun hidden", 1'b0);
            add_noise($urandom_range(0, 4));
            add_byte(CH_NL, 1'b0);
        end else if (pick < 58) begin
            add_text("/*", 1'b0);
            if ($urandom_range(0, 1)) add_text("\nfun inner\n", 1'b0);
            repeat ($urandom_range(0, 3))
                add_byte($urandom_range(0, 1) ? CH_STAR : id_char(1'b0), 1'b0);
            add_text("*/", 1'b0);
        end else if (pick < 70) begin
            q = $urandom_range(0, 1) ? CH_SQ : CH_DQ;
            add_byte(q, 1'b0);
            repeat ($urandom_range(0, 4)) begin
                case ($urandom_range(0, 4))
                    0: begin
                        add_byte(CH_BSL, 1'b0);
                        add_byte(q, 1'b0);
                    end
                    1: begin
                        add_byte(CH_BSL, 1'b0);
                        add_byte(CH_BSL, 1'b0);
                    end
                    2:       add_text("\nfun s ", 1'b0);
                    default: add_byte(id_char(1'b0), 1'b0);
                endcase
            end
            add_byte(q, 1'b0);
        end else if (pick < 84) begin
            add_noise($urandom_range(1, 6));
        end else if (pick < 94) begin
            add_byte(CH_NL, 1'b0);
        end else begin
            if ($urandom_range(0, 1)) add_byte(CH_SLASH, 1'b0);
            finish_text();
        end
    endtask

    // Idle length for either side: mostly none or short, now and then long,
    // and no idling at all in every fourth stretch of words.
    function automatic int pause_len();
        int r;
        if (((accepted_words / 160) % 4) == 3) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // ------------------------------------------------------------------------
    // Driver: offers the pending text bytes and predicts on acceptance.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
            gap      <= 0;
        end else begin
            if (s_tvalid && o_s_tready) begin
                scan_text_byte(s_tdata, s_tlast);
                accepted_words++;
                if (s_tlast) texts_done++;
            end
            if (s_tvalid && !o_s_tready) input_blocked++;
            if (!s_tvalid || o_s_tready) begin
                if (gap > 0) begin
                    gap      <= gap - 1;
                    s_tvalid <= 1'b0;
                end else if (text_words.size() > 0) begin
                    next_word = text_words.pop_front();
                    s_tvalid  <= 1'b1;
                    s_tdata   <= next_word.data;
                    s_tlast   <= next_word.last;
                    gap       <= pause_len();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: checks each name word and paces the receiver.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
            stall    <= 0;
        end else begin
            if (o_m_tvalid && m_tready) begin
                if (expected_names.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected word, expected none, actual byte %02h end %0b",
                             $realtime, o_m_tdata, o_m_tlast);
                end else begin
                    seen_word = expected_names.pop_front();
                    if (o_m_tdata !== seen_word.data) begin
                        errors++;
                        $display("%0t: name byte mismatch, expected %02h, actual %02h",
                                 $realtime, seen_word.data, o_m_tdata);
                    end
                    if (o_m_tlast !== seen_word.last) begin
                        errors++;
                        $display("%0t: name end mismatch, expected %0b, actual %0b",
                                 $realtime, seen_word.last, o_m_tlast);
                    end
                end
                name_words++;
                if (o_m_tlast) names_done++;
            end
            if (hold_off) begin
                m_tready <= 1'b0;
            end else if (stall > 0) begin
                stall    <= stall - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                stall    <= pause_len();
            end
        end
    end

    // One long hold-off on the receiver, with the sender still offering, so
    // that the output queue fills and the block has to stall its input.
    initial begin
        wait (accepted_words >= 300);
        @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    initial begin
        #6_000_000;
        $display("Timed out with %0d words still expected", expected_names.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        int base;
        reset_scanner();

        // Name closed by the end of the text: one byte yields two words.
        add_text("fun ab", 1'b1);
        // Tab after the keyword, name ended by punctuation.
        add_text("class\t_Q9(\n", 1'b0);
        // Keyword followed by a newline, by a letter, and indented.
        add_text("fun\nfunx y\n fun z\n", 1'b0);
        // Keyword and blanks with no name.
        add_text("fun \t\n", 1'b0);
        // Keywords inside comments and strings, with an escaped quote.
        add_text("//fun a\n/*\nfun b*/\"\\\"\nfun c\"\n", 1'b0);
        // Slash just before the end of the text, then the top byte values.
        add_text("a/", 1'b1);
        add_byte(8'hFF, 1'b0);
        add_byte(8'h80, 1'b1);
        // Keyword at the very end of a text.
        add_text("class", 1'b1);

        // Names longer than the limit, one ended by a newline, one by the end.
        add_text("fun ", 1'b0);
        add_name(260);
        add_byte(CH_NL, 1'b0);
        add_text("class ", 1'b0);
        add_name(256);
        finish_text();

        base = text_words.size();
        while (text_words.size() - base < RANDOM_BYTES) add_fragment();
        finish_text();

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do @(negedge i_clk);
        while (text_words.size() != 0 || s_tvalid || expected_names.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Scanned %0d text bytes in %0d texts; checked %0d name bytes in %0d names.",
                 accepted_words, texts_done, name_words, names_done);
        $display("The input was held back on %0d cycles; %0d errors.", input_blocked, errors);
        if (errors == 0 && expected_names.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
